/* src/ctrr_pkg.sv */
package ctrr_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = IDX_W + 1;
  localparam int unsigned BACKENDS      = 2;

  localparam logic [15:0] SERVICE_PORT_RST = 16'd8000;
  localparam logic [7:0]  OUTER_TTL        = 8'd64;
  localparam logic [15:0] LEN_ADD          = 16'd20;

  typedef enum logic [1:0] {
    ACT_PASS  = 2'd0,
    ACT_TX    = 2'd1,
    ACT_ABORT = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_SERVICE_PORT = 3'd0,
    REG_BALANCER_IP  = 3'd1,
    REG_BACKEND_0    = 3'd2,
    REG_BACKEND_1    = 3'd3,
    REG_BACKEND_2    = 3'd4,
    REG_BACKEND_3    = 3'd5
  } reg_idx_t;

  // sweep order: SCAN finds hit/free/lru, AGE rewrites ranks, WRITE writes slot
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_AGE,
    ST_WRITE,
    ST_CSUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        syn;
    logic        fin;
    logic        rst;
    logic [15:0] tlen;
    logic        route;
  } pkt_t;

endpackage

/* src/conntrack_round_robin_balancer_unit.sv */
// flow: pass items get their result registered in the idle state; tracked items run
// a read sweep over the table memories to find hit, free slot and lru entry, then
// a read-modify-write sweep over the recency memory to age the ranks (a miss
// without syn skips the age sweep)
// throughput: one item at a time, next item accepted once the result leaves
// reset: synchronous active-low; valid bits, rr counter and registers take reset values
module conntrack_round_robin_balancer_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // is_ipv4_tcp, src_ip, dst_ip, tcp source port, tcp destination port,
  // flag_syn, flag_fin, flag_rst, ip_total_length, route_ok, zero pad
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // action, backend_index, outer_src_ip, outer_dst_ip, outer_total_length,
  // outer_checksum, zero pad
  output logic [103:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ctrr_pkg::*;

  // config registers
  logic [15:0] service_port_r;
  logic [31:0] balancer_ip_r;
  logic [31:0] backend_ip_r [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      service_port_r <= SERVICE_PORT_RST;
      balancer_ip_r  <= '0;
      for (int i = 0; i < 4; i++) backend_ip_r[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SERVICE_PORT: service_port_r  <= cfg_data[15:0];
        REG_BALANCER_IP:  balancer_ip_r   <= cfg_data;
        REG_BACKEND_0:    backend_ip_r[0] <= cfg_data;
        REG_BACKEND_1:    backend_ip_r[1] <= cfg_data;
        REG_BACKEND_2:    backend_ip_r[2] <= cfg_data;
        REG_BACKEND_3:    backend_ip_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // table memories: key+backend in one, recency rank in the other
  localparam int unsigned KEY_W = 96;
  logic [KEY_W+1:0] key_mem [TABLE_ENTRIES];
  logic [IDX_W-1:0] rec_mem [TABLE_ENTRIES];
  logic             valid_r [TABLE_ENTRIES];

  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W+1:0] key_rd_r;
  logic [IDX_W-1:0] rec_rd_r;
  logic             key_we, rec_we;
  logic [IDX_W-1:0] key_wa, rec_wa;
  logic [KEY_W+1:0] key_wd;
  logic [IDX_W-1:0] rec_wd;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_rd_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_rd_r <= rec_mem[rd_addr];
  end

  state_t state_r, state_nxt;
  pkt_t   pkt_r;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;       // read address counter
  logic [IDX_W-1:0] pidx_r;               // index of data now on read port
  logic             pvld_r;               // read data valid this cycle
  logic             hit_r, free_r, lru_f_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r, lru_idx_r, hit_rank_r, lru_rank_r;
  logic [1:0]       hit_be_r, be_r;
  logic [31:0]      rr_r;
  logic             ins_r;   // insert path (else hit path)
  logic             del_r;   // hit then delete
  logic             evict_r; // insert with eviction
  logic [IDX_W-1:0] slot_r, old_rank_r;
  logic [103:0]     out_r;
  logic             out_v_r;
  logic [18:0]      csum_r;
  logic             tracked;

  logic [IDX_W-1:0] ptr_idx;
  assign ptr_idx = ptr_r[IDX_W-1:0];
  assign rd_addr = ptr_idx;

  assign in_tready  = (state_r == ST_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  assign tracked = in_tdata[0] && (in_tdata[96:81] == service_port_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid && in_tready && tracked) state_nxt = ST_SCAN;
      ST_SCAN:   if (ptr_r == CNT_W'(TABLE_ENTRIES) && !pvld_r) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = (hit_r || (pkt_r.syn)) ? ST_AGE : ST_OUT;
      ST_AGE:    if (ptr_r == CNT_W'(TABLE_ENTRIES) && !pvld_r) state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_CSUM;
      ST_CSUM:   state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // pointer: sweeps 0..TABLE_ENTRIES in scan and age
  always_comb begin
    ptr_nxt = ptr_r;
    if ((state_r == ST_SCAN || state_r == ST_AGE) && ptr_r != CNT_W'(TABLE_ENTRIES))
      ptr_nxt = ptr_r + 1'b1;
    else if (state_r != ST_SCAN && state_r != ST_AGE)
      ptr_nxt = '0;
  end

  // rank update for one valid entry during the age sweep
  logic [IDX_W-1:0] new_rank;
  logic             rank_chg;
  always_comb begin
    new_rank = rec_rd_r;
    rank_chg = 1'b0;
    if (ins_r) begin
      // eviction removes lru (rank count-1, nothing older) then all age by one
      if (!(evict_r && pidx_r == slot_r)) begin
        new_rank = rec_rd_r + 1'b1;
        rank_chg = 1'b1;
      end
    end else if (del_r) begin
      // touch then remove at rank 0: everything older than old rank ages
      // then everything above 0 drops; net: ranks below old stay, above drop
      if (rec_rd_r > old_rank_r) begin
        new_rank = rec_rd_r - 1'b1;
        rank_chg = 1'b1;
      end
    end else if (rec_rd_r < old_rank_r) begin
      new_rank = rec_rd_r + 1'b1;
      rank_chg = 1'b1;
    end
  end

  // memory writes
  always_comb begin
    key_we = 1'b0;
    key_wa = slot_r;
    key_wd = {be_r, pkt_r.src_ip, pkt_r.dst_ip, pkt_r.sport, pkt_r.dport};
    rec_we = 1'b0;
    rec_wa = pidx_r;
    rec_wd = new_rank;
    if (state_r == ST_AGE && pvld_r && valid_r[pidx_r] && pidx_r != slot_r && rank_chg)
      rec_we = 1'b1;
    if (state_r == ST_WRITE) begin
      rec_we = 1'b1;
      rec_wa = slot_r;
      rec_wd = '0;
      key_we = ins_r;
    end
  end

  // outer length wraps at 16 bits before it enters the checksum
  logic [15:0] olen;
  assign olen = pkt_r.tlen + LEN_ADD;

  logic [16:0] csum_fold;
  assign csum_fold = {1'b0, csum_r[15:0]} + {14'd0, csum_r[18:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r   <= '0;
      pvld_r  <= 1'b0;
      out_v_r <= 1'b0;
      rr_r    <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) valid_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      pidx_r  <= ptr_idx;
      pvld_r  <= (state_r == ST_SCAN || state_r == ST_AGE) &&
                 ptr_r != CNT_W'(TABLE_ENTRIES);
      if (out_v_r && out_tready) out_v_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          hit_r <= 1'b0; free_r <= 1'b0; lru_f_r <= 1'b0;
          if (in_tvalid && in_tready) begin
            pkt_r <= '{src_ip: in_tdata[32:1], dst_ip: in_tdata[64:33],
                       sport: in_tdata[80:65], dport: in_tdata[96:81],
                       syn: in_tdata[97], fin: in_tdata[98], rst: in_tdata[99],
                       tlen: in_tdata[115:100], route: in_tdata[116]};
            if (!tracked) begin
              out_r   <= {104{1'b0}} | 104'(ACT_PASS);
              out_v_r <= 1'b1;
            end
          end
        end
        ST_SCAN: if (pvld_r) begin
          if (valid_r[pidx_r]) begin
            if (key_rd_r[KEY_W-1:0] == {pkt_r.src_ip, pkt_r.dst_ip,
                                        pkt_r.sport, pkt_r.dport}) begin
              hit_r <= 1'b1; hit_idx_r <= pidx_r;
              hit_rank_r <= rec_rd_r; hit_be_r <= key_rd_r[KEY_W+1:KEY_W];
            end
            if (!lru_f_r || rec_rd_r >= lru_rank_r) begin
              lru_f_r <= 1'b1; lru_idx_r <= pidx_r; lru_rank_r <= rec_rd_r;
            end
          end else if (!free_r) begin
            free_r <= 1'b1; free_idx_r <= pidx_r;
          end
        end
        ST_DECIDE: begin
          ins_r   <= !hit_r;
          del_r   <= hit_r && (pkt_r.fin || pkt_r.rst);
          evict_r <= !hit_r && !free_r;
          old_rank_r <= hit_rank_r;
          if (hit_r) begin
            be_r <= hit_be_r; slot_r <= hit_idx_r;
          end else begin
            be_r   <= 2'(rr_r % BACKENDS);
            slot_r <= free_r ? free_idx_r : lru_idx_r;
            if (pkt_r.syn) rr_r <= rr_r + 1'b1;
          end
          if (!hit_r && !pkt_r.syn) out_r <= 104'(ACT_PASS);
        end
        ST_WRITE: begin
          valid_r[slot_r] <= !del_r;
          csum_r <= 19'h4500 + 19'(olen) + 19'({OUTER_TTL, 8'h04})
                    + 19'(balancer_ip_r[31:16]) + 19'(balancer_ip_r[15:0])
                    + 19'(backend_ip_r[be_r][31:16]) + 19'(backend_ip_r[be_r][15:0]);
        end
        ST_CSUM: begin
          if (!pkt_r.route)
            out_r <= {100'd0, be_r, ACT_ABORT};
          else
            out_r <= {4'd0,
                      ~(csum_fold[15:0] + {15'd0, csum_fold[16]}),
                      olen, backend_ip_r[be_r], balancer_ip_r,
                      be_r, ACT_TX};
        end
        ST_OUT: out_v_r <= 1'b1;
        default: ;
      endcase
    end
  end

  logic unused_ok;
  assign unused_ok = ^in_tdata[119:117];

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
  a_rr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DECIDE) |=> $stable(rr_r)) else $error("rr moved");
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |-> (ptr_r == CNT_W'(TABLE_ENTRIES)) || ptr_r == '0)
    else $error("sweep incomplete");
`endif

endmodule
